FILE: src/psfc_pkg.sv
// Shared constants, types and status codes for the particle sensor frame checker.
package psfc_pkg;

    // Longest burst that still counts as a frame
    localparam int MAX_FRAME_BYTES = 64;
    // Shortest frame: header, payload and a two-byte checksum
    localparam int MIN_FRAME_BYTES = 7;
    // Byte counter saturates at MAX_FRAME_BYTES + 1
    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 2);

    localparam logic [7:0] HEADER_FIRST  = 8'h42;
    localparam logic [7:0] HEADER_SECOND = 8'h4D;

    // Frame positions of the PM2.5 and PM10 bytes
    localparam int PM_FIRST_POS = 6;
    localparam int PM_LAST_POS  = 9;
    localparam int PM_BYTES     = PM_LAST_POS - PM_FIRST_POS + 1;
    localparam int PM_IDX_W     = $clog2(PM_BYTES);

    typedef logic [CNT_W-1:0] count_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_HEADER   = 3'd2,
        ST_CHECKSUM = 3'd3,
        ST_LONG     = 3'd4
    } status_t;

    // One result word
    typedef struct packed {
        status_t     status;
        logic [15:0] pm25_value;
        logic [15:0] pm10_value;
    } result_t;

endpackage

FILE: src/psfc_frame_track.sv
// Per-byte frame tracking: count, header check, running sum, PM byte capture and status.
module psfc_frame_track
    import psfc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    data_byte,
    input  logic          frame_end,
    output logic          result_fire,
    output result_t       result
);

    count_t      byte_count_reg, byte_count_next;
    logic [7:0]  older_byte_reg, older_byte_next;
    logic [7:0]  newer_byte_reg, newer_byte_next;
    logic [15:0] running_sum_reg, running_sum_next;
    logic        header_bad_reg, header_bad_next;
    logic [7:0]  pending_bytes_reg [PM_BYTES];
    logic [7:0]  pending_bytes_next [PM_BYTES];
    logic [PM_BYTES-1:0] pending_mask_reg, pending_mask_next;
    logic [7:0]  held_bytes_reg [PM_BYTES];
    logic [7:0]  held_bytes_next [PM_BYTES];

    count_t                pos;
    count_t                count_upd;
    count_t                pm_off;
    logic [PM_IDX_W-1:0]   pm_idx;
    logic                  in_pm;
    logic                  hdr_upd;
    logic [15:0]           sum_upd;
    logic [PM_BYTES-1:0]   mask_upd;
    logic [7:0]            pend_upd [PM_BYTES];
    status_t               status_w;

    assign pos    = byte_count_reg;
    assign pm_off = pos - CNT_W'(PM_FIRST_POS);
    assign pm_idx = pm_off[PM_IDX_W-1:0];
    assign in_pm  = (pos >= CNT_W'(PM_FIRST_POS)) && (pos <= CNT_W'(PM_LAST_POS));

    // Update per-burst state for the incoming word
    always_comb
    begin
        hdr_upd = header_bad_reg
                | ((pos == CNT_W'(0)) && (data_byte != HEADER_FIRST))
                | ((pos == CNT_W'(1)) && (data_byte != HEADER_SECOND));
        sum_upd = (pos >= CNT_W'(2)) ? running_sum_reg + {8'h00, older_byte_reg}
                                     : running_sum_reg;
        count_upd = (pos <= CNT_W'(MAX_FRAME_BYTES)) ? pos + CNT_W'(1) : pos;
        mask_upd = pending_mask_reg;
        for (int i = 0; i < PM_BYTES; i++)
        begin
            pend_upd[i] = pending_bytes_reg[i];
        end
        if (in_pm)
        begin
            mask_upd[pm_idx] = 1'b1;
            pend_upd[pm_idx] = data_byte;
        end
    end

    // Classify the finished frame, most serious short/long checks first
    always_comb
    begin
        if (count_upd < CNT_W'(MIN_FRAME_BYTES))
            status_w = ST_SHORT;
        else if (count_upd > CNT_W'(MAX_FRAME_BYTES))
            status_w = ST_LONG;
        else if (hdr_upd)
            status_w = ST_HEADER;
        else if ({newer_byte_reg, data_byte} != sum_upd)
            status_w = ST_CHECKSUM;
        else
            status_w = ST_OK;
    end

    // Commit held PM bytes on a good frame, clear burst state at its end
    always_comb
    begin
        byte_count_next  = byte_count_reg;
        older_byte_next  = older_byte_reg;
        newer_byte_next  = newer_byte_reg;
        running_sum_next = running_sum_reg;
        header_bad_next  = header_bad_reg;
        pending_mask_next = pending_mask_reg;
        for (int i = 0; i < PM_BYTES; i++)
        begin
            pending_bytes_next[i] = pending_bytes_reg[i];
            held_bytes_next[i]    = held_bytes_reg[i];
        end
        if (accept)
        begin
            if (frame_end)
            begin
                byte_count_next   = '0;
                older_byte_next   = '0;
                newer_byte_next   = '0;
                running_sum_next  = '0;
                header_bad_next   = 1'b0;
                pending_mask_next = '0;
                for (int i = 0; i < PM_BYTES; i++)
                begin
                    pending_bytes_next[i] = '0;
                    if ((status_w == ST_OK) && mask_upd[i])
                        held_bytes_next[i] = pend_upd[i];
                end
            end
            else
            begin
                byte_count_next   = count_upd;
                older_byte_next   = newer_byte_reg;
                newer_byte_next   = data_byte;
                running_sum_next  = sum_upd;
                header_bad_next   = hdr_upd;
                pending_mask_next = mask_upd;
                for (int i = 0; i < PM_BYTES; i++)
                begin
                    pending_bytes_next[i] = pend_upd[i];
                end
            end
        end
    end

    // Result word for the current frame end
    assign result_fire       = accept && frame_end;
    assign result.status     = status_w;
    assign result.pm25_value = {held_bytes_next[0], held_bytes_next[1]};
    assign result.pm10_value = {held_bytes_next[2], held_bytes_next[3]};

    // Hold state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            older_byte_reg   <= '0;
            newer_byte_reg   <= '0;
            running_sum_reg  <= '0;
            header_bad_reg   <= 1'b0;
            pending_mask_reg <= '0;
            for (int i = 0; i < PM_BYTES; i++)
            begin
                pending_bytes_reg[i] <= '0;
                held_bytes_reg[i]    <= '0;
            end
        end
        else
        begin
            byte_count_reg   <= byte_count_next;
            older_byte_reg   <= older_byte_next;
            newer_byte_reg   <= newer_byte_next;
            running_sum_reg  <= running_sum_next;
            header_bad_reg   <= header_bad_next;
            pending_mask_reg <= pending_mask_next;
            for (int i = 0; i < PM_BYTES; i++)
            begin
                pending_bytes_reg[i] <= pending_bytes_next[i];
                held_bytes_reg[i]    <= held_bytes_next[i];
            end
        end
    end

    // Counter never runs past its saturation point
    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= CNT_W'(MAX_FRAME_BYTES + 1))
        else $error("byte count past saturation");

    // A frame end leaves a fresh burst behind
    a_burst_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && frame_end |=> (byte_count_reg == '0) && (pending_mask_reg == '0)
                                && !header_bad_reg)
        else $error("burst state not cleared after frame end");

    // Captured PM positions never outrun the byte count
    a_mask_vs_count: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_count_reg <= CNT_W'(PM_FIRST_POS)) |-> (pending_mask_reg == '0))
        else $error("PM byte captured before its position");

endmodule

FILE: src/particle_sensor_frame_checker_core.sv
// Top level of the particle sensor frame checker: input handshake and two-entry result buffer.
//
// Takes one received sensor byte per cycle while byte_stall is low, with no gaps needed
// between bytes; the per-byte state (count, two-byte delay, running sum, header flag, PM
// captures) updates in the cycle a word is accepted. On the word flagged frame_end, a
// status word with the held PM2.5 and PM10 values is registered into the output register,
// or into the skid entry while a result waits. Results sit in an output register backed
// by one skid entry, so input words keep flowing while a result waits; byte_stall rises
// only when both entries are full. Status: too short, too long, bad header, bad checksum,
// else ok (reported in that order of precedence). Frames longer than the buffer limit are
// flagged, never overrun, and only a good frame updates the held PM words.
module particle_sensor_frame_checker_core
    import psfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  status,
    output logic [15:0] pm25_value,
    output logic [15:0] pm10_value
);

    logic    accept;
    logic    new_fire;
    result_t new_result;
    logic    out_taken;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;

    assign byte_stall = skid_valid_reg;
    assign accept     = byte_valid && !byte_stall;
    assign out_taken  = out_valid_reg && !result_stall;

    psfc_frame_track u_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (data_byte),
        .frame_end   (frame_end),
        .result_fire (new_fire),
        .result      (new_result)
    );

    // Advance the output register and skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_taken)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = new_fire;
                skid_data_next  = new_result;
            end
            else
            begin
                out_data_next  = new_result;
                out_valid_next = new_fire;
            end
        end
        else if (new_fire)
        begin
            skid_data_next  = new_result;
            skid_valid_next = 1'b1;
        end
    end

    // Hold result handshake state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold result payload
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign result_valid = out_valid_reg;
    assign status       = out_data_reg.status;
    assign pm25_value   = out_data_reg.pm25_value;
    assign pm10_value   = out_data_reg.pm10_value;

    // Skid entry only fills behind a waiting result
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full with empty output register");

    // A buffered result survives while the output stays stalled
    a_skid_kept: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && result_stall |=> skid_valid_reg && out_valid_reg)
        else $error("buffered result dropped under stall");

    // A frame end reaches the output in the next cycle when the path is clear
    a_result_lat: assert property (@(posedge clk) disable iff (!rst_n)
        accept && frame_end && !out_valid_reg |=> out_valid_reg)
        else $error("frame end produced no result");

endmodule

FILE: tb/sv/psfc_result_checker.sv
// Result checker for the particle sensor frame checker: predicts each status word and compares.
`timescale 1ns / 1ps

module psfc_result_checker
    import psfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    input  logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [2:0]  status,
    input  logic [15:0] pm25_value,
    input  logic [15:0] pm10_value,
    output int          mismatch_count,
    output int          frames_outstanding
);

    // Burst tracking state, mirrored from the block's behavior
    count_t              burst_len;
    logic [7:0]          prev2_byte;
    logic [7:0]          prev1_byte;
    logic [15:0]         sum_before_tail;
    logic                hdr_fault;
    logic [7:0]          pm_capture [PM_BYTES];
    logic [PM_BYTES-1:0] pm_seen;
    logic [7:0]          pm_held [PM_BYTES];

    // Status words still owed by the block, oldest first
    result_t             frame_status_q [$];

    task automatic clear_burst_state();
        burst_len       = '0;
        prev2_byte      = '0;
        prev1_byte      = '0;
        sum_before_tail = '0;
        hdr_fault       = 1'b0;
        pm_seen         = '0;
        for (int i = 0; i < PM_BYTES; i++)
        begin
            pm_capture[i] = '0;
        end
    endtask

    // Advance the burst state by one sensor byte; queue a status word at burst end
    task automatic absorb_sensor_byte(input logic [7:0] b, input logic last);
        int      pos;
        status_t st;
        result_t word;
        pos = int'(burst_len);
        if (pos == 0 && b != HEADER_FIRST)
            hdr_fault = 1'b1;
        if (pos == 1 && b != HEADER_SECOND)
            hdr_fault = 1'b1;
        if (pos >= PM_FIRST_POS && pos <= PM_LAST_POS)
        begin
            pm_capture[pos - PM_FIRST_POS] = b;
            pm_seen[pos - PM_FIRST_POS]    = 1'b1;
        end
        // Keep the newest two bytes out of the sum
        if (pos >= 2)
            sum_before_tail = sum_before_tail + 16'(prev2_byte);
        prev2_byte = prev1_byte;
        prev1_byte = b;
        if (pos <= MAX_FRAME_BYTES)
            burst_len = burst_len + 1'b1;
        if (last)
        begin
            if (int'(burst_len) < MIN_FRAME_BYTES)
                st = ST_SHORT;
            else if (int'(burst_len) > MAX_FRAME_BYTES)
                st = ST_LONG;
            else if (hdr_fault)
                st = ST_HEADER;
            else if ({prev2_byte, prev1_byte} != sum_before_tail)
                st = ST_CHECKSUM;
            else
                st = ST_OK;
            // Only a good frame refreshes the held PM bytes it delivered
            if (st == ST_OK)
            begin
                for (int i = 0; i < PM_BYTES; i++)
                begin
                    if (pm_seen[i])
                        pm_held[i] = pm_capture[i];
                end
            end
            word.status     = st;
            word.pm25_value = {pm_held[0], pm_held[1]};
            word.pm10_value = {pm_held[2], pm_held[3]};
            frame_status_q.push_back(word);
            clear_burst_state();
        end
    endtask

    // Compare a delivered status word against the oldest prediction
    task automatic check_status_word();
        result_t want;
        if (frame_status_q.size() == 0)
        begin
            $display("%0t: unexpected status word: status %0d pm25 %04h pm10 %04h",
                     $time, status, pm25_value, pm10_value);
            mismatch_count++;
        end
        else
        begin
            want = frame_status_q.pop_front();
            if (status != want.status)
            begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, status);
                mismatch_count++;
            end
            if (pm25_value != want.pm25_value)
            begin
                $display("%0t: pm25_value mismatch: expected %04h, actual %04h",
                         $time, want.pm25_value, pm25_value);
                mismatch_count++;
            end
            if (pm10_value != want.pm10_value)
            begin
                $display("%0t: pm10_value mismatch: expected %04h, actual %04h",
                         $time, want.pm10_value, pm10_value);
                mismatch_count++;
            end
        end
    endtask

    // Sample both channels at each edge; outputs first, since a word never answers same-edge input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_burst_state();
            for (int i = 0; i < PM_BYTES; i++)
            begin
                pm_held[i] = '0;
            end
            frame_status_q.delete();
            mismatch_count     = 0;
            frames_outstanding = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
                check_status_word();
            if (byte_valid && !byte_stall)
                absorb_sensor_byte(data_byte, frame_end);
            frames_outstanding = frame_status_q.size();
        end
    end

endmodule

FILE: tb/sv/particle_sensor_frame_checker_core_tb.sv
// Testbench top for the particle sensor frame checker: byte stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module particle_sensor_frame_checker_core_tb
    import psfc_pkg::*;
();

    localparam int CYCLE_LIMIT       = 200000;
    localparam int LONG_HOLD_CYCLES  = 400;
    localparam int RANDOM_BYTES      = 1700;
    localparam int FILL_RANDOM       = 0;
    localparam int FILL_ZEROS        = 1;
    localparam int FILL_ONES         = 2;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        byte_valid   = 1'b0;
    logic        byte_stall;
    logic [7:0]  data_byte    = 8'h00;
    logic        frame_end    = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [2:0]  status;
    logic [15:0] pm25_value;
    logic [15:0] pm10_value;

    int          mismatch_count;
    int          frames_outstanding;
    int          bytes_sent     = 0;
    int          cycle_count    = 0;
    bit          tx_idle_on     = 1'b1;
    bit          rx_idle_on     = 1'b1;
    bit          long_hold_req  = 1'b0;
    logic [7:0]  burst_bytes [$];

    particle_sensor_frame_checker_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .frame_end    (frame_end),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .pm25_value   (pm25_value),
        .pm10_value   (pm10_value)
    );

    psfc_result_checker i_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .byte_valid         (byte_valid),
        .byte_stall         (byte_stall),
        .data_byte          (data_byte),
        .frame_end          (frame_end),
        .result_valid       (result_valid),
        .result_stall       (result_stall),
        .status             (status),
        .pm25_value         (pm25_value),
        .pm10_value         (pm10_value),
        .mismatch_count     (mismatch_count),
        .frames_outstanding (frames_outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Bound the run length
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Drive result_stall: random bursts, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD_CYCLES;
            end
            else if (hold_left == 0 && rx_idle_on && $urandom_range(0, 7) == 0)
            begin
                hold_left = $urandom_range(1, 16);
            end
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    // Offer one word, with an optional idle burst first; return on the accepting edge
    task automatic send_word(input logic [7:0] b, input logic last);
        if (tx_idle_on && $urandom_range(0, 9) == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        byte_valid <= 1'b1;
        data_byte  <= b;
        frame_end  <= last;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_burst();
        for (int i = 0; i < burst_bytes.size(); i++)
        begin
            send_word(burst_bytes[i], i == burst_bytes.size() - 1);
        end
    endtask

    // Build a burst: good header (len >= 4), matching checksum in its last two bytes (len >= 2)
    task automatic build_frame(input int len, input int fill);
        logic [15:0] sum;
        logic [7:0]  b;
        burst_bytes.delete();
        sum = '0;
        for (int i = 0; i < len - 2; i++)
        begin
            if (i == 0)
                b = HEADER_FIRST;
            else if (i == 1)
                b = HEADER_SECOND;
            else if (fill == FILL_ZEROS)
                b = 8'h00;
            else if (fill == FILL_ONES)
                b = 8'hFF;
            else
                b = 8'($urandom_range(0, 255));
            sum = sum + 16'(b);
            burst_bytes.push_back(b);
        end
        if (len >= 2)
        begin
            burst_bytes.push_back(sum[15:8]);
            burst_bytes.push_back(sum[7:0]);
        end
        else
        begin
            burst_bytes.push_back(HEADER_FIRST);
        end
    endtask

    // Corrupt one byte of the current burst
    task automatic flip_byte(input int idx);
        burst_bytes[idx] = burst_bytes[idx] ^ 8'($urandom_range(1, 255));
    endtask

    initial
    begin
        int pick;
        int len;
        bit hold_issued;
        hold_issued = 1'b0;

        // Hold reset, then release on an edge
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed bursts: size limits, every status and its precedence
        build_frame(7, FILL_RANDOM);
        send_burst();
        build_frame(8, FILL_ONES);
        send_burst();
        build_frame(9, FILL_ZEROS);
        send_burst();
        build_frame(10, FILL_RANDOM);
        send_burst();
        build_frame(MAX_FRAME_BYTES, FILL_RANDOM);
        send_burst();
        build_frame(20, FILL_ONES);
        send_burst();
        build_frame(10, FILL_ZEROS);
        send_burst();
        build_frame(1, FILL_RANDOM);
        send_burst();
        build_frame(MIN_FRAME_BYTES - 1, FILL_RANDOM);
        send_burst();
        build_frame(5, FILL_RANDOM);
        flip_byte(0);
        send_burst();
        build_frame(12, FILL_RANDOM);
        flip_byte(0);
        send_burst();
        build_frame(12, FILL_RANDOM);
        flip_byte(1);
        send_burst();
        build_frame(12, FILL_RANDOM);
        flip_byte(10);
        send_burst();
        build_frame(12, FILL_RANDOM);
        flip_byte(11);
        send_burst();
        build_frame(MAX_FRAME_BYTES + 1, FILL_RANDOM);
        send_burst();
        build_frame(200, FILL_RANDOM);
        flip_byte(1);
        send_burst();
        build_frame(10, FILL_RANDOM);
        send_burst();

        // Random bursts, mostly well-formed frames with random content
        while (bytes_sent < RANDOM_BYTES)
        begin
            if (bytes_sent >= 1400)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            else if (bytes_sent >= 900)
            begin
                tx_idle_on = 1'b1;
                rx_idle_on = 1'b1;
            end
            else if (bytes_sent >= 600)
            begin
                // Fill the result buffer: stop the receiver, keep offering bytes
                if (!hold_issued)
                begin
                    long_hold_req = 1'b1;
                    hold_issued   = 1'b1;
                end
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end

            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(MIN_FRAME_BYTES, MAX_FRAME_BYTES);
            else
                len = $urandom_range(MIN_FRAME_BYTES, 16);
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                build_frame(len, FILL_RANDOM);
            end
            else if (pick < 78)
            begin
                build_frame(len, FILL_RANDOM);
                flip_byte($urandom_range(len - 2, len - 1));
            end
            else if (pick < 85)
            begin
                build_frame(len, FILL_RANDOM);
                flip_byte($urandom_range(0, 1));
            end
            else if (pick < 92)
            begin
                build_frame($urandom_range(1, MIN_FRAME_BYTES - 1), FILL_RANDOM);
            end
            else if (pick < 95)
            begin
                build_frame($urandom_range(MAX_FRAME_BYTES + 1, MAX_FRAME_BYTES + 30),
                            FILL_RANDOM);
            end
            else
            begin
                // Line noise: random bytes of random length
                burst_bytes.delete();
                repeat ($urandom_range(1, 20))
                    burst_bytes.push_back(8'($urandom_range(0, 255)));
            end
            send_burst();
        end

        // Drain outstanding status words, then settle
        byte_valid <= 1'b0;
        @(posedge clk);
        while (frames_outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && frames_outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
